// ===== hdl/i2da_pkg.sv =====
// Shared constants for the binary to decimal ASCII converter.
// No dependencies.
package i2da_pkg;
  localparam int unsigned WORD_BITS = 64;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [3:0] DIGIT_ADD_LIMIT = 4'd5;
  localparam logic [3:0] DIGIT_ADD = 4'd3;
endpackage

// ===== hdl/i2da_if.sv =====
// Stream interfaces for input words and output characters.
// Depends on i2da_pkg.
interface i2da_in_if import i2da_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] value;
  logic                 is_signed;
  modport source (output valid, value, is_signed, input ready);
  modport sink (input valid, value, is_signed, output ready);
endinterface

interface i2da_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  modport source (output valid, character, last, input ready);
  modport sink (input valid, character, last, output ready);
endinterface

// ===== hdl/i2da_dabble_stage.sv =====
// One registered shift-add-3 step of the binary to BCD pipeline.
// Depends on i2da_pkg.
module i2da_dabble_stage import i2da_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned DIGITS = 20
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     valid_in,
  input  logic                     neg_in,
  input  logic [4*DIGITS-1:0]      bcd_in,
  input  logic [VALUE_WIDTH-1:0]   bin_in,
  output logic                     valid,
  output logic                     neg,
  output logic [4*DIGITS-1:0]      bcd,
  output logic [VALUE_WIDTH-1:0]   bin
);
  logic [4*DIGITS-1:0] adj;

  // Add three to each digit of five or more
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_in[4*d +: 4] >= DIGIT_ADD_LIMIT) begin
        adj[4*d +: 4] = bcd_in[4*d +: 4] + DIGIT_ADD;
      end else begin
        adj[4*d +: 4] = bcd_in[4*d +: 4];
      end
    end
  end

  // Shift the next binary bit into the digits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
    if (advance) begin
      neg <= neg_in;
      bcd <= {adj[4*DIGITS-2:0], bin_in[VALUE_WIDTH-1]};
      bin <= {bin_in[VALUE_WIDTH-2:0], 1'b0};
    end
  end
endmodule

// ===== hdl/i2da_serializer.sv =====
// Emits sign and digits of one converted word as ASCII beats.
// Depends on i2da_pkg and i2da_out_if.
module i2da_serializer import i2da_pkg::*; #(
  parameter int unsigned DIGITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  input  logic                load_neg,
  input  logic [4*DIGITS-1:0] load_bcd,
  output logic                take,
  i2da_out_if.source          out
);
  localparam int unsigned IW = $clog2(DIGITS);

  logic                busy;
  logic                minus_pending;
  logic [IW-1:0]       idx;
  logic [4*DIGITS-1:0] bcd;
  logic [IW-1:0]       top_idx;
  logic                emit;

  assign take = !busy;
  assign emit = busy && (!out.valid || out.ready);

  // Find the most significant nonzero digit
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (load_bcd[4*d +: 4] != 4'd0) begin
        top_idx = IW'(d);
      end
    end
  end

  // Load a word, then step down through its digits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      if (out.valid && out.ready && !emit) begin
        out.valid <= 1'b0;
      end
      if (!busy && load_valid) begin
        busy <= 1'b1;
      end else if (emit) begin
        out.valid <= 1'b1;
        if (!minus_pending && idx == '0) begin
          busy <= 1'b0;
        end
      end
    end
    if (!busy && load_valid) begin
      bcd <= load_bcd;
      minus_pending <= load_neg;
      idx <= top_idx;
    end else if (emit) begin
      if (minus_pending) begin
        minus_pending <= 1'b0;
        out.character <= CHAR_MINUS;
        out.last <= 1'b0;
      end else begin
        out.character <= CHAR_ZERO | {4'd0, bcd[4*idx +: 4]};
        out.last <= (idx == '0);
        if (idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (32'(idx) < DIGITS)) else $error("digit index out of range");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && !minus_pending && idx == '0) |=> (!busy && out.valid && out.last))
    else $error("final digit not marked last");
  a_minus_first: assert property (@(posedge clk) disable iff (rst)
    (emit && minus_pending) |=> (busy && out.character == CHAR_MINUS && !out.last))
    else $error("sign beat misplaced");
endmodule

// ===== hdl/integer_to_decimal_ascii_top.sv =====
// Top level: sign handling, shift-add-3 pipeline, character serializer.
// Depends on i2da_pkg, i2da_if, i2da_dabble_stage, i2da_serializer.
// Throughput: one character per cycle while out.ready is high; the serializer takes
// a new word only after the last character (1 to 20 at VALUE_WIDTH 64) of the previous one.
// The pipeline holds VALUE_WIDTH + 1 words in flight, one bit step per dabble stage.
// Synchronous active-high reset clears all valid bits; no words are kept.
module integer_to_decimal_ascii_top import i2da_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  i2da_in_if.sink     in,
  i2da_out_if.source  out
);
  localparam int unsigned DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;

  logic                   valid [0:VALUE_WIDTH];
  logic                   neg   [0:VALUE_WIDTH];
  logic [4*DIGITS-1:0]    bcd   [0:VALUE_WIDTH];
  logic [VALUE_WIDTH-1:0] bin   [0:VALUE_WIDTH];
  logic                   advance;
  logic                   take;
  logic [VALUE_WIDTH-1:0] word;
  logic                   word_neg;

  // Stall the whole pipeline while the serializer is busy and the last stage holds a word
  assign advance = !valid[VALUE_WIDTH] || take;
  assign in.ready = advance;

  assign word = in.value[VALUE_WIDTH-1:0];
  assign word_neg = in.is_signed && word[VALUE_WIDTH-1];

  // Register the magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (advance) begin
      valid[0] <= in.valid;
    end
    if (advance) begin
      neg[0] <= word_neg;
      bcd[0] <= '0;
      bin[0] <= word_neg ? (~word + 1'b1) : word;
    end
  end

  for (genvar s = 0; s < VALUE_WIDTH; s++) begin : g_stage
    i2da_dabble_stage #(.VALUE_WIDTH(VALUE_WIDTH), .DIGITS(DIGITS)) u_stage (
      .clk(clk), .rst(rst), .advance(advance),
      .valid_in(valid[s]), .neg_in(neg[s]), .bcd_in(bcd[s]), .bin_in(bin[s]),
      .valid(valid[s+1]), .neg(neg[s+1]), .bcd(bcd[s+1]), .bin(bin[s+1])
    );
  end

  i2da_serializer #(.DIGITS(DIGITS)) u_ser (
    .clk(clk), .rst(rst),
    .load_valid(valid[VALUE_WIDTH]), .load_neg(neg[VALUE_WIDTH]),
    .load_bcd(bcd[VALUE_WIDTH]), .take(take), .out(out)
  );
endmodule
